>>> sv/assert_macros.svh
// assertion macros shared by the timer table rtl
// no dependencies; the SYNTH define drops every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, disabled while in reset
`define TCPTW_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, disabled while in reset
`define TCPTW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TCPTW_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define TCPTW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> sv/tcptw_pkg.sv
// shared types, sizes and codes of the tcp timer table
// no dependencies; used by every other file of the block but assert_macros.svh
package tcptw_pkg;

  // table size and time range
  localparam int SOCKETS    = 16;
  localparam int TIME_BITS  = 24;
  localparam int SOCK_IDX_W = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;

  // field widths of the channels
  localparam int OP_W       = 3;
  localparam int SOCK_W     = 4;
  localparam int RES_W      = 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_STEP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEWAIT_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETRANS_BASE   = 2'd2;

  // wide enough for any saturating sum of two time values
  localparam int SUM_W = 33;
  localparam logic [SUM_W-1:0] TIME_MAX = (SUM_W'(1) << TIME_BITS) - SUM_W'(1);

  // command queue between front and engine
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // input op codes
  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_ARM_TW    = 3'd1;
  localparam logic [OP_W-1:0] OP_ARM_RT    = 3'd2;
  localparam logic [OP_W-1:0] OP_DISARM_RT = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_PEND  = 3'd4;

  // event codes
  localparam logic [RES_W-1:0] EV_CLOSE = 2'd0;
  localparam logic [RES_W-1:0] EV_RETX  = 2'd1;
  localparam logic [RES_W-1:0] EV_RESET = 2'd2;

  // retries allowed before a reset
  localparam logic [1:0] RETRY_MAX = 2'd3;

  typedef logic [TIME_BITS-1:0] time_t;

  // decoded command kinds
  typedef enum logic [2:0] {
    K_TICK,
    K_ARM_TW,
    K_ARM_RT,
    K_DISARM_RT,
    K_SET_PEND
  } cmd_kind_t;

  // queue word
  typedef struct packed {
    cmd_kind_t             kind;
    logic [SOCK_IDX_W-1:0] socket;
    logic                  pending;
  } cmd_t;

  // configuration register set
  typedef struct packed {
    logic [15:0] tick_step;
    logic [23:0] timewait_limit;
    logic [20:0] retrans_base;
  } cfg_t;

endpackage

>>> sv/tcptw_if.sv
// handshake channels of the timer table: command words in, event words out
// depends on tcptw_pkg for field widths
interface tcptw_item_if;
  logic                          valid;
  logic                          ready;
  logic [tcptw_pkg::OP_W-1:0]    op;
  logic [tcptw_pkg::SOCK_W-1:0]  socket;
  logic                          pending;

  modport source (output valid, output op, output socket, output pending, input ready);
  modport sink   (input valid, input op, input socket, input pending, output ready);
endinterface

interface tcptw_evt_if;
  logic                          valid;
  logic                          ready;
  logic [tcptw_pkg::RES_W-1:0]   event_res;
  logic [tcptw_pkg::SOCK_W-1:0]  event_socket;
  logic                          last;

  modport source (output valid, output event_res, output event_socket, output last,
                  input ready);
  modport sink   (input valid, input event_res, input event_socket, input last,
                  output ready);
endinterface

>>> sv/tcptw_front.sv
// front end: takes command words, decodes them and drops ignored ones
// depends on tcptw_pkg and tcptw_item_if
module tcptw_front (
  tcptw_item_if.sink       item,
  input  logic             q_full,
  output logic             q_push,
  output tcptw_pkg::cmd_t  q_push_word
);

  logic                  keep;
  logic                  in_range;
  tcptw_pkg::cmd_kind_t  kind;

  // accept whenever the queue has room
  assign item.ready = !q_full;

  assign in_range = (32'(item.socket) < tcptw_pkg::SOCKETS);

  // op decode; unknown ops and out-of-range sockets are dropped here
  always_comb begin
    keep = 1'b0;
    kind = tcptw_pkg::K_TICK;
    unique case (item.op)
      tcptw_pkg::OP_TICK: begin
        keep = 1'b1;
      end
      tcptw_pkg::OP_ARM_TW: begin
        kind = tcptw_pkg::K_ARM_TW;
        keep = in_range;
      end
      tcptw_pkg::OP_ARM_RT: begin
        kind = tcptw_pkg::K_ARM_RT;
        keep = in_range;
      end
      tcptw_pkg::OP_DISARM_RT: begin
        kind = tcptw_pkg::K_DISARM_RT;
        keep = in_range;
      end
      tcptw_pkg::OP_SET_PEND: begin
        kind = tcptw_pkg::K_SET_PEND;
        keep = in_range;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // queue write
  assign q_push              = item.valid && item.ready && keep;
  assign q_push_word.kind    = kind;
  assign q_push_word.socket  = tcptw_pkg::SOCK_IDX_W'(item.socket);
  assign q_push_word.pending = item.pending;

endmodule

>>> sv/tcptw_queue.sv
// short command queue between the decoder and the table engine
// depends on tcptw_pkg for the word type and depth
module tcptw_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tcptw_pkg::cmd_t  push_word,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output tcptw_pkg::cmd_t  q_word
);

  tcptw_pkg::cmd_t                  slots [tcptw_pkg::QDEPTH];
  logic [tcptw_pkg::QPTR_W-1:0]     wr_ptr;
  logic [tcptw_pkg::QPTR_W-1:0]     rd_ptr;
  logic [tcptw_pkg::QCNT_W-1:0]     count;

  assign full    = (count == tcptw_pkg::QCNT_W'(tcptw_pkg::QDEPTH));
  assign q_valid = (count != '0);
  assign q_word  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == tcptw_pkg::QPTR_W'(tcptw_pkg::QDEPTH - 1)) ? '0
                                                                        : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == tcptw_pkg::QPTR_W'(tcptw_pkg::QDEPTH - 1)) ? '0
                                                                        : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/tcptw_engine.sv
// table engine: per-socket timer state, command execution and the tick scan
// depends on tcptw_pkg, tcptw_evt_if and assert_macros.svh
`include "assert_macros.svh"

module tcptw_engine (
  input  logic             clk,
  input  logic             rst,
  input  tcptw_pkg::cfg_t  cfg,
  input  logic             q_valid,
  input  tcptw_pkg::cmd_t  q_word,
  output logic             q_pop,
  tcptw_evt_if.source      evt
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // per-socket timer table
  logic             tw_act  [tcptw_pkg::SOCKETS];
  tcptw_pkg::time_t tw_el   [tcptw_pkg::SOCKETS];
  logic             rt_act  [tcptw_pkg::SOCKETS];
  tcptw_pkg::time_t rt_el   [tcptw_pkg::SOCKETS];
  tcptw_pkg::time_t rt_lim  [tcptw_pkg::SOCKETS];
  logic [1:0]       rt_cnt  [tcptw_pkg::SOCKETS];
  logic             pend    [tcptw_pkg::SOCKETS];

  state_t                          st;
  logic [tcptw_pkg::SOCK_IDX_W-1:0] scan_sock;
  logic                            scan_ph;

  // event waiting to learn whether it is the last of its tick
  logic                            held_v;
  logic [tcptw_pkg::RES_W-1:0]     held_res;
  logic [tcptw_pkg::SOCK_IDX_W-1:0] held_sock;

  // output register
  logic                            out_valid;
  logic [tcptw_pkg::RES_W-1:0]     out_res;
  logic [tcptw_pkg::SOCK_IDX_W-1:0] out_sock;
  logic                            out_last;

  logic [tcptw_pkg::SOCK_IDX_W-1:0] idx;
  logic             cur_tw_act;
  logic             cur_rt_act;
  logic             cur_pend;
  logic [1:0]       cur_cnt;
  tcptw_pkg::time_t cur_rt_lim;
  tcptw_pkg::time_t tw_sum;
  tcptw_pkg::time_t rt_sum;
  tcptw_pkg::time_t lim_dbl;
  tcptw_pkg::time_t arm_lim;
  logic             tw_hit;
  logic             rt_hit;
  logic             rt_give_up;
  logic             ev_found;
  logic [tcptw_pkg::RES_W-1:0] ev_res;
  logic             out_free;
  logic             step_go;
  logic             last_step;
  logic             scan_wr;
  logic             out_load;

  function automatic tcptw_pkg::time_t sat_add(input logic [tcptw_pkg::SUM_W-1:0] a,
                                               input logic [tcptw_pkg::SUM_W-1:0] b);
    logic [tcptw_pkg::SUM_W-1:0] s;
    s = a + b;
    return (s > tcptw_pkg::TIME_MAX) ? tcptw_pkg::TIME_BITS'(tcptw_pkg::TIME_MAX)
                                     : tcptw_pkg::TIME_BITS'(s);
  endfunction

  // one table row is read at a time: the command socket or the scan socket
  assign idx        = (st == ST_IDLE) ? q_word.socket : scan_sock;
  assign cur_tw_act = tw_act[idx];
  assign cur_rt_act = rt_act[idx];
  assign cur_pend   = pend[idx];
  assign cur_cnt    = rt_cnt[idx];
  assign cur_rt_lim = rt_lim[idx];

  // advance and expiry check of the row under the scan
  assign tw_sum     = sat_add(tcptw_pkg::SUM_W'(tw_el[idx]), tcptw_pkg::SUM_W'(cfg.tick_step));
  assign rt_sum     = sat_add(tcptw_pkg::SUM_W'(rt_el[idx]), tcptw_pkg::SUM_W'(cfg.tick_step));
  assign lim_dbl    = sat_add(tcptw_pkg::SUM_W'(cur_rt_lim), tcptw_pkg::SUM_W'(cur_rt_lim));
  assign tw_hit     = cur_tw_act &&
                      (tcptw_pkg::SUM_W'(tw_sum) >= tcptw_pkg::SUM_W'(cfg.timewait_limit));
  assign rt_hit     = cur_rt_act && cur_pend && (rt_sum >= cur_rt_lim);
  assign rt_give_up = (cur_cnt >= tcptw_pkg::RETRY_MAX);

  // initial retransmission limit, clipped to the time range
  assign arm_lim = (tcptw_pkg::SUM_W'(cfg.retrans_base) > tcptw_pkg::TIME_MAX)
                   ? tcptw_pkg::TIME_BITS'(tcptw_pkg::TIME_MAX)
                   : tcptw_pkg::TIME_BITS'(cfg.retrans_base);

  // event of this scan step: time-wait phase first, then retransmission
  assign ev_found = scan_ph ? rt_hit : tw_hit;
  assign ev_res   = !scan_ph ? tcptw_pkg::EV_CLOSE
                  : (rt_give_up ? tcptw_pkg::EV_RESET : tcptw_pkg::EV_RETX);

  // a step stalls only when it must push the held word into a busy output
  assign out_free  = !out_valid || evt.ready;
  assign step_go   = !ev_found || !held_v || out_free;
  assign last_step = scan_ph && (scan_sock == tcptw_pkg::SOCK_IDX_W'(tcptw_pkg::SOCKETS - 1));
  assign scan_wr   = (st == ST_SCAN) && step_go;

  // output register loads a held word mid-tick or at the final flush
  assign out_load  = (scan_wr && ev_found && held_v) || ((st == ST_FLUSH) && out_free);

  assign q_pop = (st == ST_IDLE) && q_valid;

  // output channel
  assign evt.valid        = out_valid;
  assign evt.event_res    = out_res;
  assign evt.event_socket = tcptw_pkg::SOCK_W'(out_sock);
  assign evt.last         = out_last;

  // table updates: commands when idle, timer advance during the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tcptw_pkg::SOCKETS; i++) begin
        tw_act[i] <= 1'b0;
        tw_el[i]  <= '0;
        rt_act[i] <= 1'b0;
        rt_el[i]  <= '0;
        rt_lim[i] <= '0;
        rt_cnt[i] <= '0;
        pend[i]   <= 1'b0;
      end
    end else if (q_pop) begin
      unique case (q_word.kind)
        tcptw_pkg::K_ARM_TW: begin
          tw_act[idx] <= 1'b1;
          tw_el[idx]  <= '0;
        end
        tcptw_pkg::K_ARM_RT: begin
          rt_act[idx] <= 1'b1;
          rt_el[idx]  <= '0;
          rt_lim[idx] <= arm_lim;
          rt_cnt[idx] <= '0;
        end
        tcptw_pkg::K_DISARM_RT: begin
          rt_act[idx] <= 1'b0;
        end
        tcptw_pkg::K_SET_PEND: begin
          pend[idx] <= q_word.pending;
        end
        tcptw_pkg::K_TICK: begin
        end
        default: begin
        end
      endcase
    end else if (scan_wr) begin
      if (!scan_ph) begin
        if (cur_tw_act) begin
          tw_el[idx] <= tw_sum;
        end
        if (tw_hit) begin
          tw_act[idx] <= 1'b0;
        end
      end else begin
        if (cur_rt_act) begin
          rt_el[idx] <= rt_sum;
        end
        if (rt_hit) begin
          if (rt_give_up) begin
            rt_act[idx] <= 1'b0;
          end else begin
            rt_lim[idx] <= lim_dbl;
            rt_cnt[idx] <= cur_cnt + 2'd1;
          end
        end
      end
    end
  end

  // scan sequencer, held event and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      scan_sock <= '0;
      scan_ph   <= 1'b0;
      held_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && evt.ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (q_pop && (q_word.kind == tcptw_pkg::K_TICK)) begin
            st        <= ST_SCAN;
            scan_sock <= '0;
            scan_ph   <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (step_go) begin
            if (ev_found) begin
              if (held_v) begin
                out_res   <= held_res;
                out_sock  <= held_sock;
                out_last  <= 1'b0;
              end
              held_v    <= 1'b1;
              held_res  <= ev_res;
              held_sock <= scan_sock;
            end
            if (last_step) begin
              st <= (held_v || ev_found) ? ST_FLUSH : ST_IDLE;
            end else begin
              scan_ph <= !scan_ph;
              if (scan_ph) begin
                scan_sock <= scan_sock + 1'b1;
              end
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            out_res   <= held_res;
            out_sock  <= held_sock;
            out_last  <= 1'b1;
            held_v    <= 1'b0;
            st        <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  `TCPTW_ASSERT_IMPL(a_held_in_tick, clk, rst, held_v, (st == ST_SCAN) || (st == ST_FLUSH), "held event outside a tick")
  `TCPTW_ASSERT_NEXT(a_mid_not_last, clk, rst, scan_wr && ev_found && held_v, out_valid && !out_last, "mid-tick event marked last")
  `TCPTW_ASSERT_NEXT(a_flush_last, clk, rst, (st == ST_FLUSH) && out_free, out_valid && out_last && !held_v && (st == ST_IDLE), "final event not flushed")
  `TCPTW_ASSERT_NEXT(a_tick_start, clk, rst, q_pop && (q_word.kind == tcptw_pkg::K_TICK), (st == ST_SCAN) && (scan_sock == '0) && !scan_ph, "scan did not start at socket zero")

endmodule

>>> sv/tcp_timewait_retrans_timer_table_unit.sv
// top level of the tcp time-wait and retransmission timer table
// depends on tcptw_pkg, tcptw_if, tcptw_front, tcptw_queue and tcptw_engine
//
// Commands arm a socket's timers, disarm its retransmission timer or set its
// pending-data flag and produce no events; a tick advances every active timer
// by tick_step and reports closes, retransmits and resets in socket order, the
// final event of the tick flagged with last. Commands enter a two-entry queue
// behind the decoder and are executed by the table engine. A tick occupies the
// engine while it is taken from the queue and its timers are scanned one at a
// time, since the table has a single row read port, plus a flush step to
// release the last event when the tick has any, and longer while the event
// output is stalled. The input keeps accepting into the queue during a tick
// until it fills. Reset clears the whole table; configuration registers are
// written with cfg_we, cfg_index and cfg_data.
module tcp_timewait_retrans_timer_table_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tcptw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcptw_pkg::CFG_DATA_W-1:0]  cfg_data,
  tcptw_item_if.sink                        item,
  tcptw_evt_if.source                       evt
);

  tcptw_pkg::cfg_t  cfg;
  logic             q_push;
  tcptw_pkg::cmd_t  q_push_word;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  tcptw_pkg::cmd_t  q_word;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_step      <= 16'd10;
      cfg.timewait_limit <= 24'd60000;
      cfg.retrans_base   <= 21'd200;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcptw_pkg::REG_TICK_STEP:      cfg.tick_step      <= cfg_data[15:0];
        tcptw_pkg::REG_TIMEWAIT_LIMIT: cfg.timewait_limit <= cfg_data[23:0];
        tcptw_pkg::REG_RETRANS_BASE:   cfg.retrans_base   <= cfg_data[20:0];
        default: begin
        end
      endcase
    end
  end

  // decoder
  tcptw_front u_front (
    .item        (item),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_word (q_push_word)
  );

  // command queue
  tcptw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (q_push_word),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_word    (q_word)
  );

  // timer table engine
  tcptw_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_pop   (q_pop),
    .evt     (evt)
  );

endmodule
